// ===== hw/rtl/spcp_pkg.sv =====
// Shared constants, types and arithmetic helpers for the spline closest-point block.
`default_nettype none
package spcp_pkg;

	// Table and sampling geometry
	localparam int MAX_WAYPOINTS = 64;
	localparam int SAMPLES       = 20;
	localparam int ADDR_W        = $clog2(MAX_WAYPOINTS);
	localparam int CNT_W         = $clog2(MAX_WAYPOINTS + 1);
	localparam int J_W           = $clog2(SAMPLES + 1);

	// Port field widths
	localparam int COORD_W   = 32;
	localparam int INDEX_W   = 6;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 7;

	// Spline arithmetic: curve numerator is an integer over DEN = 2*S^3
	localparam longint S2   = SAMPLES * SAMPLES;
	localparam longint S3   = S2 * SAMPLES;
	localparam longint DEN  = 2 * S3;
	localparam longint HALF = S3;

	localparam int CP_W = COORD_W + 2;   // control point, extrapolated ends included
	localparam int DW   = 48;            // coefficients and forward differences
	localparam int QW   = 40;            // quotient part of a difference
	localparam int RW   = $clog2(DEN);   // remainder part of a difference

	// Shared divider by DEN: DIV_STEPS quotient bits per cycle
	localparam int DIV_STEPS = 8;
	localparam int DVD_W     = 56;
	localparam int DIV_CYC   = DVD_W / DIV_STEPS;
	localparam int BIAS_SH   = 34;

	// Command codes
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LOOP_MODE      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WAYPOINT_COUNT = 2'd1;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [QW-1:0] quo_t;
	typedef logic [RW-1:0] rem_t;

	// Value held as q*DEN + r with 0 <= r < DEN
	typedef struct packed {
		quo_t q;
		rem_t r;
	} fd_t;

	// Add two quotient/remainder pairs and renormalize the remainder
	function automatic fd_t fd_add(input fd_t a, input fd_t b);
		logic [RW:0] rs;
		logic cy;
		fd_t res;
		rs = {1'b0, a.r} + {1'b0, b.r};
		cy = (rs >= (RW + 1)'(DEN));
		if (cy) begin
			rs = rs - (RW + 1)'(DEN);
		end
		res.q = a.q + b.q + QW'(cy);
		res.r = rs[RW-1:0];
		return res;
	endfunction

	// Clamp a wide quotient to the signed coordinate range
	function automatic coord_t sat_coord(input quo_t v);
		coord_t res;
		if ((&v[QW-1:COORD_W-1]) || !(|v[QW-1:COORD_W-1])) begin
			res = v[COORD_W-1:0];
		end else if (v[QW-1]) begin
			res = {1'b1, {(COORD_W - 1){1'b0}}};
		end else begin
			res = {1'b0, {(COORD_W - 1){1'b1}}};
		end
		return res;
	endfunction

	// Exact square of a coordinate difference
	function automatic logic [2*COORD_W-1:0] sq_diff(input coord_t a, input coord_t b);
		logic signed [COORD_W:0] d;
		logic [COORD_W:0] nd;
		logic [COORD_W-1:0] m;
		d  = {a[COORD_W-1], a} - {b[COORD_W-1], b};
		nd = -d;
		m  = d[COORD_W] ? nd[COORD_W-1:0] : d[COORD_W-1:0];
		return {{COORD_W{1'b0}}, m} * {{COORD_W{1'b0}}, m};
	endfunction

	// Saturating add of squared distances
	function automatic logic [2*COORD_W-1:0] sat_add(input logic [2*COORD_W-1:0] a,
			input logic [2*COORD_W-1:0] b);
		logic [2*COORD_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[2*COORD_W] ? {(2 * COORD_W){1'b1}} : s[2*COORD_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/spcp_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none
module spcp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== hw/rtl/spline_path_closest_point.sv =====
// Top level: waypoint table and closest sampled point on a Catmull-Rom path.
//
// A write request stores one waypoint. A query request with no waypoints answers
// zero, with one waypoint answers waypoint 0. Otherwise each segment is handled in
// steps: fetch its four control points from the waypoint RAM, extrapolate open ends,
// set up forward differences per coordinate through the shared divider by 16000
// (eight quotient bits per cycle, nine divisions), and walk the 21 samples, one
// coordinate per cycle through the single squarer plus a compare step. A query covers
// as many segments as the waypoint count in loop mode, one less in open mode. The
// request channel stalls for the whole query; a finished result waits in the response
// register, and the block is held only while the previous result is still stalled.
`default_nettype none
module spline_path_closest_point (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// configuration write channel
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [spcp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [spcp_pkg::CFG_W-1:0]        cfg_data,
	// request channel
	input  wire logic                              req_valid,
	output logic                                   req_stall,
	input  wire logic                              command,
	input  wire logic [spcp_pkg::INDEX_W-1:0]      index,
	input  wire logic signed [spcp_pkg::COORD_W-1:0] pos_x,
	input  wire logic signed [spcp_pkg::COORD_W-1:0] pos_y,
	input  wire logic signed [spcp_pkg::COORD_W-1:0] pos_z,
	// response channel
	output logic                                   rsp_valid,
	input  wire logic                              rsp_stall,
	output logic signed [spcp_pkg::COORD_W-1:0]    closest_x,
	output logic signed [spcp_pkg::COORD_W-1:0]    closest_y,
	output logic signed [spcp_pkg::COORD_W-1:0]    closest_z
);

	import spcp_pkg::*;

	localparam int ST_W = 4;
	localparam logic [ST_W-1:0] ST_IDLE    = 4'd0;
	localparam logic [ST_W-1:0] ST_ONE_RD  = 4'd1;
	localparam logic [ST_W-1:0] ST_ONE_CAP = 4'd2;
	localparam logic [ST_W-1:0] ST_FETCH   = 4'd3;
	localparam logic [ST_W-1:0] ST_EXTRAP  = 4'd4;
	localparam logic [ST_W-1:0] ST_COEF    = 4'd5;
	localparam logic [ST_W-1:0] ST_DIFF    = 4'd6;
	localparam logic [ST_W-1:0] ST_DLOAD   = 4'd7;
	localparam logic [ST_W-1:0] ST_DSTEP   = 4'd8;
	localparam logic [ST_W-1:0] ST_SAMP    = 4'd9;
	localparam logic [ST_W-1:0] ST_DONE    = 4'd10;

	localparam int RAM_W = 3 * COORD_W;
	localparam int SQ_W  = 2 * COORD_W;

	localparam logic signed [DW-1:0] K_S2 = DW'(S2);
	localparam logic signed [DW-1:0] K_S  = DW'(SAMPLES);
	localparam logic signed [DW-1:0] K_2S = DW'(2 * SAMPLES);
	localparam logic signed [DW-1:0] K_6  = DW'(6);
	localparam logic [DVD_W-1:0] DIV_BIAS = DVD_W'(DEN) << BIAS_SH;
	localparam logic [DVD_W-1:0] DIV_ONE  = DVD_W'(1) << BIAS_SH;
	localparam logic [RW:0] DEN_X = (RW + 1)'(DEN);
	localparam logic [2:0] DIV_LAST = 3'(DIV_CYC - 1);

	// Control and configuration registers
	logic [ST_W-1:0]  state_q;
	logic             loop_mode_q;
	logic [CFG_W-1:0] count_q;
	logic [CNT_W-1:0] n_q;
	logic [ADDR_W-1:0] seg_q;
	logic [2:0]       fk_q;
	logic [1:0]       crd_q;
	logic [1:0]       mi_q;
	logic [2:0]       dcnt_q;
	logic [J_W-1:0]   j_q;
	logic             found_q;
	logic             rsp_valid_q;

	// Datapath registers
	coord_t           qpt_q [3];
	logic signed [CP_W-1:0] cp_q [4][3];
	logic signed [DW-1:0] cb_q, cc_q, cd_q;
	logic signed [DW-1:0] dv_q [3];
	logic [DVD_W-1:0] dvd_q, quo_q;
	rem_t             rem_q;
	fd_t              fd_q [3][4];
	coord_t           samp_q [3];
	logic [SQ_W-1:0]  sq_s1;
	logic [SQ_W-1:0]  acc_q;
	logic [SQ_W-1:0]  best_q;
	coord_t           best_pt_q [3];
	coord_t           rsp_x_q, rsp_y_q, rsp_z_q;

	// RAM ports
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [ADDR_W-1:0] ram_raddr;
	logic [RAM_W-1:0]  ram_rdata;

	logic req_acc;
	logic [CNT_W-1:0] n_clamp;
	logic [CNT_W-1:0] segs;
	logic seg_last;
	logic [1:0] crd_k;
	logic [CNT_W:0] a0, a2, a3, seg_x;

	// Handshakes
	assign cfg_ready = 1'b1;
	assign req_stall = (state_q != ST_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign closest_x = rsp_x_q;
	assign closest_y = rsp_y_q;
	assign closest_z = rsp_z_q;

	// Waypoint table
	assign ram_we    = req_acc && (command == CMD_WRITE) && (32'(index) < MAX_WAYPOINTS);
	assign ram_waddr = ADDR_W'(index);

	spcp_ram #(
		.WIDTH(RAM_W),
		.DEPTH(MAX_WAYPOINTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata({pos_z, pos_y, pos_x}),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Clamp count, derive segment bookkeeping
	assign n_clamp  = (32'(count_q) > MAX_WAYPOINTS) ? CNT_W'(MAX_WAYPOINTS) : CNT_W'(count_q);
	assign segs     = loop_mode_q ? n_q : n_q - CNT_W'(1);
	assign seg_last = (CNT_W'(seg_q) + CNT_W'(1) == segs);
	assign crd_k    = (crd_q == 2'd3) ? 2'd0 : crd_q;

	// Control point addresses with wraparound
	always_comb begin
		seg_x = (CNT_W + 1)'(seg_q);
		a0 = (seg_q == '0) ? (CNT_W + 1)'(n_q) - (CNT_W + 1)'(1) : seg_x - (CNT_W + 1)'(1);
		a2 = seg_x + (CNT_W + 1)'(1);
		if (a2 >= (CNT_W + 1)'(n_q)) begin
			a2 = a2 - (CNT_W + 1)'(n_q);
		end
		a3 = seg_x + (CNT_W + 1)'(2);
		if (a3 >= (CNT_W + 1)'(n_q)) begin
			a3 = a3 - (CNT_W + 1)'(n_q);
		end
	end

	always_comb begin
		ram_raddr = '0;
		if (state_q == ST_FETCH) begin
			unique case (fk_q[1:0])
				2'd0: ram_raddr = a0[ADDR_W-1:0];
				2'd1: ram_raddr = seg_q;
				2'd2: ram_raddr = a2[ADDR_W-1:0];
				default: ram_raddr = a3[ADDR_W-1:0];
			endcase
		end
	end

	// Cubic coefficients of the current coordinate
	logic signed [DW-1:0] p0, p1, p2, p3, cb_n, cc_n, cd_n;
	always_comb begin
		p0 = DW'(cp_q[0][crd_k]);
		p1 = DW'(cp_q[1][crd_k]);
		p2 = DW'(cp_q[2][crd_k]);
		p3 = DW'(cp_q[3][crd_k]);
		cb_n = p2 - p0;
		cc_n = (p0 <<< 1) - ((p1 <<< 2) + p1) + (p2 <<< 2) - p3;
		cd_n = ((p1 <<< 1) + p1) - ((p2 <<< 1) + p2) + p3 - p0;
	end

	// Divider: DIV_STEPS restoring steps per cycle
	logic [DVD_W-1:0] dvd_n, quo_n;
	rem_t rem_n;
	logic [RW:0] rx;
	always_comb begin
		dvd_n = dvd_q;
		quo_n = quo_q;
		rem_n = rem_q;
		rx    = '0;
		for (int s = 0; s < DIV_STEPS; s++) begin
			rx    = {rem_n, dvd_n[DVD_W-1]};
			dvd_n = dvd_n << 1;
			if (rx >= DEN_X) begin
				rx    = rx - DEN_X;
				quo_n = {quo_n[DVD_W-2:0], 1'b1};
			end else begin
				quo_n = {quo_n[DVD_W-2:0], 1'b0};
			end
			rem_n = rx[RW-1:0];
		end
	end

	// Sample of the current coordinate and its squared distance
	coord_t s_val;
	logic [SQ_W-1:0] sq_n, dist_n;
	logic [DVD_W-1:0] quo_unb;
	always_comb begin
		s_val   = sat_coord(fd_q[crd_k][0].q);
		sq_n    = sq_diff(s_val, qpt_q[crd_k]);
		dist_n  = sat_add(acc_q, sq_s1);
		quo_unb = quo_n - DIV_ONE;
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_mode_q <= 1'b0;
			count_q     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_LOOP_MODE) begin
				loop_mode_q <= cfg_data[0];
			end else if (cfg_index == REG_WAYPOINT_COUNT) begin
				count_q <= cfg_data;
			end
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q     <= '0;
			seg_q   <= '0;
			fk_q    <= '0;
			crd_q   <= '0;
			mi_q    <= '0;
			dcnt_q  <= '0;
			j_q     <= '0;
			found_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_acc && (command == CMD_QUERY)) begin
						n_q     <= n_clamp;
						found_q <= 1'b0;
						seg_q   <= '0;
						fk_q    <= '0;
						crd_q   <= '0;
						mi_q    <= '0;
						j_q     <= '0;
						if (n_clamp == '0) begin
							state_q <= ST_DONE;
						end else if (n_clamp == CNT_W'(1)) begin
							state_q <= ST_ONE_RD;
						end else begin
							state_q <= ST_FETCH;
						end
					end
				end
				ST_ONE_RD: state_q <= ST_ONE_CAP;
				ST_ONE_CAP: state_q <= ST_DONE;
				ST_FETCH: begin
					fk_q <= fk_q + 3'd1;
					if (fk_q == 3'd4) begin
						state_q <= ST_EXTRAP;
					end
				end
				ST_EXTRAP: state_q <= ST_COEF;
				ST_COEF: state_q <= ST_DIFF;
				ST_DIFF: begin
					mi_q    <= '0;
					state_q <= ST_DLOAD;
				end
				ST_DLOAD: begin
					dcnt_q  <= '0;
					state_q <= ST_DSTEP;
				end
				ST_DSTEP: begin
					dcnt_q <= dcnt_q + 3'd1;
					if (dcnt_q == DIV_LAST) begin
						if (mi_q == 2'd2) begin
							mi_q <= '0;
							if (crd_q == 2'd2) begin
								crd_q   <= '0;
								j_q     <= '0;
								state_q <= ST_SAMP;
							end else begin
								crd_q   <= crd_q + 2'd1;
								state_q <= ST_COEF;
							end
						end else begin
							mi_q    <= mi_q + 2'd1;
							state_q <= ST_DLOAD;
						end
					end
				end
				ST_SAMP: begin
					crd_q <= crd_q + 2'd1;
					if (crd_q == 2'd3) begin
						found_q <= 1'b1;
						if (j_q == J_W'(SAMPLES)) begin
							j_q <= '0;
							if (seg_last) begin
								state_q <= ST_DONE;
							end else begin
								seg_q   <= seg_q + ADDR_W'(1);
								fk_q    <= '0;
								state_q <= ST_FETCH;
							end
						end else begin
							j_q <= j_q + J_W'(1);
						end
					end
				end
				ST_DONE: begin
					if (!rsp_valid_q || !rsp_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				qpt_q[0] <= pos_x;
				qpt_q[1] <= pos_y;
				qpt_q[2] <= pos_z;
				best_q   <= '1;
				for (int k = 0; k < 3; k++) begin
					best_pt_q[k] <= '0;
				end
			end
			ST_ONE_CAP: begin
				for (int k = 0; k < 3; k++) begin
					best_pt_q[k] <= ram_rdata[k*COORD_W +: COORD_W];
				end
			end
			ST_FETCH: begin
				// Capture the point addressed in the previous cycle
				if (fk_q != 3'd0) begin
					for (int k = 0; k < 3; k++) begin
						cp_q[fk_q[1:0] - 2'd1][k] <=
							CP_W'($signed(ram_rdata[k*COORD_W +: COORD_W]));
					end
				end
			end
			ST_EXTRAP: begin
				// Extrapolate missing ends of an open path
				for (int k = 0; k < 3; k++) begin
					if (!loop_mode_q && (seg_q == '0)) begin
						cp_q[0][k] <= (cp_q[1][k] <<< 1) - cp_q[2][k];
					end
					if (!loop_mode_q && (seg_x + (CNT_W + 1)'(2) >= (CNT_W + 1)'(n_q))) begin
						cp_q[3][k] <= (cp_q[2][k] <<< 1) - cp_q[1][k];
					end
				end
			end
			ST_COEF: begin
				cb_q <= cb_n;
				cc_q <= cc_n;
				cd_q <= cd_n;
				// Starting value: numerator plus half the divisor is p1*DEN + HALF
				fd_q[crd_k][0].q <= QW'(cp_q[1][crd_k]);
				fd_q[crd_k][0].r <= RW'(HALF);
			end
			ST_DIFF: begin
				dv_q[0] <= cb_q * K_S2 + cc_q * K_S + cd_q;
				dv_q[1] <= cc_q * K_2S + cd_q * K_6;
				dv_q[2] <= cd_q * K_6;
			end
			ST_DLOAD: begin
				dvd_q <= DVD_W'(dv_q[mi_q]) + DIV_BIAS;
				quo_q <= '0;
				rem_q <= '0;
			end
			ST_DSTEP: begin
				dvd_q <= dvd_n;
				quo_q <= quo_n;
				rem_q <= rem_n;
				if (dcnt_q == DIV_LAST) begin
					fd_q[crd_k][mi_q + 2'd1].q <= QW'(quo_unb);
					fd_q[crd_k][mi_q + 2'd1].r <= rem_n;
				end
			end
			ST_SAMP: begin
				if (crd_q != 2'd3) begin
					// Sample one coordinate, square it, advance its differences
					samp_q[crd_k]   <= s_val;
					sq_s1           <= sq_n;
					fd_q[crd_k][0]  <= fd_add(fd_q[crd_k][0], fd_q[crd_k][1]);
					fd_q[crd_k][1]  <= fd_add(fd_q[crd_k][1], fd_q[crd_k][2]);
					fd_q[crd_k][2]  <= fd_add(fd_q[crd_k][2], fd_q[crd_k][3]);
					if (crd_q == 2'd1) begin
						acc_q <= sq_s1;
					end else if (crd_q == 2'd2) begin
						acc_q <= sat_add(acc_q, sq_s1);
					end
				end else begin
					// Keep the first strict minimum
					if (!found_q || (dist_n < best_q)) begin
						best_q <= dist_n;
						for (int k = 0; k < 3; k++) begin
							best_pt_q[k] <= samp_q[k];
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && (!rsp_valid_q || !rsp_stall)) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && (!rsp_valid_q || !rsp_stall)) begin
			rsp_x_q <= best_pt_q[0];
			rsp_y_q <= best_pt_q[1];
			rsp_z_q <= best_pt_q[2];
		end
	end

endmodule
`default_nettype wire
